[design/iqfg_pkg.sv]
// ----------------------------------------------------------------------------
// iqfg_pkg: shared types and constants for the indication queue
// Queue depth, byte limits, operation codes and the controller command word.
// ----------------------------------------------------------------------------
package iqfg_pkg;

    // queue geometry
    localparam int QUEUE_ENTRIES = 16;
    localparam int MAX_BYTES     = 5;
    localparam int PTR_W         = $clog2(QUEUE_ENTRIES);
    localparam int CNT_W         = $clog2(QUEUE_ENTRIES + 1);

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 3;
    localparam int BYTES_W  = 40;
    localparam int NBYTES   = BYTES_W / 8;
    localparam int ENTRY_W  = HANDLE_W + LEN_W + BYTES_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_CONFIRM = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd3;

    // controller to datapath command word
    typedef struct packed {
        logic capture;   // latch the input word
        logic update;    // apply the operation to the queue state
        logic pop;       // read the head and advance
        logic load_out;  // load the result register
    } t_cmd;

    // keep only the low 'len' bytes of a data word
    function automatic logic [BYTES_W-1:0] f_byte_mask(input logic [LEN_W-1:0] len);
        logic [BYTES_W-1:0] m;
        m = '0;
        for (int i = 0; i < NBYTES; i++) begin
            if (LEN_W'(i) < len) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // circular pointer step, any depth
    function automatic logic [PTR_W-1:0] f_advance(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_ENTRIES - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

[design/iqfg_ctrl.sv]
// ----------------------------------------------------------------------------
// iqfg_ctrl: sequencer for the indication queue
// Walks each accepted word through update, optional pop and result load.
// ----------------------------------------------------------------------------
module iqfg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  logic          i_send_ok,
    output iqfg_pkg::t_cmd o_cmd
);
    import iqfg_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_POP    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_load;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign w_accept = i_valid && o_ready;
    // result register free when empty or being drained this cycle
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = i_send_ok ? S_POP : S_DONE;
            end
            S_POP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // commands
    always_comb begin
        o_cmd.capture  = w_accept;
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.pop      = (r_state == S_POP);
        o_cmd.load_out = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[design/iqfg_dp.sv]
// ----------------------------------------------------------------------------
// iqfg_dp: datapath for the indication queue
// Entry memory, read/write pointers, full/empty marks, in-flight flag, result.
// ----------------------------------------------------------------------------
module iqfg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iqfg_pkg::t_cmd                i_cmd,
    output logic                          o_send_ok,
    input  logic [iqfg_pkg::OP_W-1:0]     i_operation,
    input  logic [iqfg_pkg::HANDLE_W-1:0] i_item_handle,
    input  logic [iqfg_pkg::LEN_W-1:0]    i_item_length,
    input  logic [iqfg_pkg::BYTES_W-1:0]  i_item_bytes,
    output logic                          o_send_valid,
    output logic [iqfg_pkg::HANDLE_W-1:0] o_send_handle,
    output logic [iqfg_pkg::LEN_W-1:0]    o_send_length,
    output logic [iqfg_pkg::BYTES_W-1:0]  o_send_bytes,
    output logic                          o_rejected,
    output logic [iqfg_pkg::CNT_W-1:0]    o_entries_held,
    output logic                          o_busy_res
);
    import iqfg_pkg::*;

    // latched input word
    logic [OP_W-1:0]     r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_len;
    logic [BYTES_W-1:0]  r_bytes;

    // queue state
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_full, n_full;
    logic             r_empty, n_empty;
    logic             r_busy, n_busy;
    logic             r_sent, n_sent;
    logic             r_rej, n_rej;

    // entry memory
    logic [ENTRY_W-1:0] r_mem [QUEUE_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               w_len_ok;
    logic               w_push;
    logic [PTR_W-1:0]   w_wr_next;
    logic [PTR_W-1:0]   w_rd_next;
    logic [CNT_W-1:0]   w_held;

    assign w_len_ok  = (r_len != '0) && (r_len <= LEN_W'(MAX_BYTES));
    assign w_push    = i_cmd.update && (r_op == OP_ENQUEUE) && w_len_ok && !r_full;
    assign w_wr_next = f_advance(r_wr_ptr);
    assign w_rd_next = f_advance(r_rd_ptr);

    // send check against the state left by the update step
    assign o_send_ok = ((r_op == OP_ENQUEUE) || (r_op == OP_CONFIRM))
                       && !n_busy && !n_empty;

    // queue state update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_full   = r_full;
        n_empty  = r_empty;
        n_busy   = r_busy;
        n_sent   = r_sent;
        n_rej    = r_rej;
        if (i_cmd.capture) begin
            n_sent = 1'b0;
            n_rej  = 1'b0;
        end
        if (i_cmd.update) begin
            case (r_op)
                OP_ENQUEUE: begin
                    n_rej = !(w_len_ok && !r_full);
                    if (w_push) begin
                        n_wr_ptr = w_wr_next;
                        n_empty  = 1'b0;
                        n_full   = (w_wr_next == r_rd_ptr);
                    end
                end
                OP_CONFIRM: n_busy = 1'b0;
                OP_TIMEOUT: n_busy = 1'b0;
                OP_RESET: begin
                    n_wr_ptr = '0;
                    n_rd_ptr = '0;
                    n_full   = 1'b0;
                    n_empty  = 1'b1;
                    n_busy   = 1'b0;
                end
                default: n_busy = r_busy;
            endcase
        end
        if (i_cmd.pop) begin
            n_rd_ptr = w_rd_next;
            n_full   = 1'b0;
            n_empty  = (w_rd_next == r_wr_ptr);
            n_busy   = 1'b1;
            n_sent   = 1'b1;
        end
    end

    // entries waiting
    always_comb begin
        if (r_full) begin
            w_held = CNT_W'(QUEUE_ENTRIES);
        end else if (r_wr_ptr >= r_rd_ptr) begin
            w_held = CNT_W'(r_wr_ptr) - CNT_W'(r_rd_ptr);
        end else begin
            w_held = CNT_W'(r_wr_ptr) + CNT_W'(QUEUE_ENTRIES) - CNT_W'(r_rd_ptr);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_full   <= 1'b0;
            r_empty  <= 1'b1;
            r_busy   <= 1'b0;
            r_sent   <= 1'b0;
            r_rej    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_full   <= n_full;
            r_empty  <= n_empty;
            r_busy   <= n_busy;
            r_sent   <= n_sent;
            r_rej    <= n_rej;
        end
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_handle <= i_item_handle;
            r_len    <= i_item_length;
            r_bytes  <= i_item_bytes;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= {r_handle, r_len, r_bytes & f_byte_mask(r_len)};
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // result register; send fields read zero when nothing went out
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_send_valid   <= r_sent;
            o_send_handle  <= r_sent ? r_rd_data[ENTRY_W-1 -: HANDLE_W] : '0;
            o_send_length  <= r_sent ? r_rd_data[BYTES_W +: LEN_W] : '0;
            o_send_bytes   <= r_sent ? r_rd_data[BYTES_W-1:0] : '0;
            o_rejected     <= r_rej;
            o_entries_held <= w_held;
            o_busy_res     <= r_busy;
        end
    end

endmodule

[design/indication_queue_with_flow_gate.sv]
// ----------------------------------------------------------------------------
// indication_queue_with_flow_gate: one indication in flight, rest queued
// Each accepted word steps through update, pop (only when sent, reading the
// registered read port of the entry memory) and done, where the result loads
// once the result register is free; no new word is taken until back in idle.
// Reset clears pointers, marks and in-flight; entry memory is not cleared.
// ----------------------------------------------------------------------------
module indication_queue_with_flow_gate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [iqfg_pkg::OP_W-1:0]     i_operation,
    input  logic [iqfg_pkg::HANDLE_W-1:0] i_item_handle,
    input  logic [iqfg_pkg::LEN_W-1:0]    i_item_length,
    input  logic [iqfg_pkg::BYTES_W-1:0]  i_item_bytes,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_send_valid,
    output logic [iqfg_pkg::HANDLE_W-1:0] o_send_handle,
    output logic [iqfg_pkg::LEN_W-1:0]    o_send_length,
    output logic [iqfg_pkg::BYTES_W-1:0]  o_send_bytes,
    output logic                          o_rejected,
    output logic [iqfg_pkg::CNT_W-1:0]    o_entries_held,
    output logic                          o_busy_res
);
    import iqfg_pkg::*;

    t_cmd w_cmd;
    logic w_send_ok;

    // sequencer
    iqfg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_send_ok (w_send_ok),
        .o_cmd     (w_cmd)
    );

    // queue datapath
    iqfg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_send_ok      (w_send_ok),
        .i_operation    (i_operation),
        .i_item_handle  (i_item_handle),
        .i_item_length  (i_item_length),
        .i_item_bytes   (i_item_bytes),
        .o_send_valid   (o_send_valid),
        .o_send_handle  (o_send_handle),
        .o_send_length  (o_send_length),
        .o_send_bytes   (o_send_bytes),
        .o_rejected     (o_rejected),
        .o_entries_held (o_entries_held),
        .o_busy_res     (o_busy_res)
    );

    // a sent word always leaves an indication in flight
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_valid) |-> o_busy_res)
        else $error("send without in-flight");

    // nothing sent means zeroed send fields
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_send_valid) |->
        (o_send_handle == '0 && o_send_length == '0 && o_send_bytes == '0))
        else $error("send fields not cleared");

    // one word at a time: no accept right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while busy");

    // held count stays within the queue depth
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entries_held <= CNT_W'(QUEUE_ENTRIES)))
        else $error("held count out of range");

endmodule
